/* rtl/core/flns_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the force layout node step block.
// No dependencies; imported by the core, flns_mul and the bench.

package flns_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int MAX_EDGES       = 255;

  localparam int REQ_W     = 2;
  localparam int EDGE_W    = 8;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 40;
  localparam int ADIV_W    = 26;

  // fixed-point scaling of the two force terms
  localparam int REPEL_SHIFT = 15;
  localparam int ATTR_SHIFT  = 7;
  // distances at or beyond 2^BIG_BIT give a repulsion term under one LSB
  localparam int BIG_BIT     = 31;
  localparam int QUO_MIN_W   = 32;

  localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPEL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ATTRACT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD   = 2'd2;

  localparam logic [CFG_W-1:0] WEIGHT_RST = 16'd256;
  localparam logic [CFG_W-1:0] GAIN_RST   = 16'd150;
  localparam logic [CFG_W-1:0] DEAD_RST   = 16'd256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_ACC,
    S_DEAD,
    S_OUT
  } flns_state_t;

endpackage

`default_nettype wire

/* rtl/core/force_layout_node_step_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Force-directed layout: next position of one node from a set of items.
// Depends on flns_pkg, flns_mul (serial multiplier), flns_div (serial divider).
//
// Usage: an item is taken at a clock edge with start high and busy low.
// A set is a start item (own position, edge count, held flag), then any
// number of repel items (other scene nodes) and attract items (edge
// neighbors); the item with in_last high closes the set. Exactly one cycle
// of out_valid then carries out_new_x/out_new_y (saturated) and out_moved.
// The receiver cannot stall; the strobe comes regardless.
// Each item is registered and decoded in S_PREP. A start item, an unused
// type or a skipped repel/attract item goes straight back to S_IDLE; an
// attract item passes S_DIV and S_ACC, a repel item S_MUL, S_DIV and S_ACC.
// The repel path uses the bit-serial multiplier for the squares and the
// gain products, and every force term comes from the bit-serial divider
// (Q = max(32, W+7) quotient bits, W = COORD_WIDTH). An item with in_last
// then passes S_DEAD and S_OUT; out_valid is high in the cycle the block
// goes idle again. No new item is taken until the block is back in S_IDLE.
// Configuration registers may be written at any time the block is idle.
// Reset clears position, velocities, held flag and edge divisor to zero
// and loads the register defaults; no result is pending after reset.

module force_layout_node_step_core #(
  parameter int COORD_WIDTH = flns_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [flns_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_y,
  input  logic [flns_pkg::EDGE_W-1:0]       in_edge_count,
  input  logic                              in_held,
  input  logic                              in_last,
  output logic                              out_valid,
  output logic signed [COORD_WIDTH-1:0]     out_new_x,
  output logic signed [COORD_WIDTH-1:0]     out_new_y,
  output logic                              out_moved,
  input  logic                              cfg_wr_en,
  input  logic [flns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [flns_pkg::CFG_W-1:0]        cfg_wdata
);
  import flns_pkg::*;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int MAG_W  = COORD_WIDTH;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int NUM_W  = PROD_W + REPEL_SHIFT;
  localparam int SQ_W   = 2 * MAG_W + 1;
  localparam int DEN_W  = (SQ_W > ADIV_W) ? SQ_W : ADIV_W;
  localparam int QUO_W  = (COORD_WIDTH + ATTR_SHIFT > QUO_MIN_W) ?
                          COORD_WIDTH + ATTR_SHIFT : QUO_MIN_W;
  localparam int SUM_W  = ((ACC_W > QUO_W + 1) ? ACC_W : QUO_W + 1) + 1;
  localparam int POS_W  = ((ACC_W > COORD_WIDTH) ? ACC_W : COORD_WIDTH) + 1;

  // ---------------------------------------------------------------- registers
  flns_state_t state_r, state_nxt;

  logic [CFG_W-1:0] weight_r, weight_nxt;
  logic [CFG_W-1:0] gain_r, gain_nxt;
  logic [CFG_W-1:0] dz_r, dz_nxt;

  logic [REQ_W-1:0]              req_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic [EDGE_W-1:0]             edge_r;
  logic                          held_in_r, last_r;

  logic signed [COORD_WIDTH-1:0] self_x_r, self_x_nxt, self_y_r, self_y_nxt;
  logic                          held_r, held_nxt;
  logic signed [ACC_W-1:0]       vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic [ADIV_W-1:0]             adiv_r, adiv_nxt;
  logic                          sx_r, sx_nxt, sy_r, sy_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [COORD_WIDTH-1:0] new_x_r, new_x_nxt, new_y_r, new_y_nxt;
  logic                          moved_r, moved_nxt;

  // ---------------------------------------------------------------- control
  logic ld_item, ld_start, prep_en, mul_go, div_go, use_mul;
  logic acc_en, dead_en, out_en;

  // ---------------------------------------------------------------- datapath
  logic signed [DIFF_W-1:0] dsub_x, dsub_y;
  logic [MAG_W-1:0]         mag_x, mag_y;
  logic                     rep_skip, att_skip;

  logic [EDGE_W-1:0]  edge_cl;
  logic [EDGE_W:0]    edge_p1;
  logic [CFG_W-1:0]   w_eff;
  logic [ADIV_W-1:0]  adiv_new;

  logic               mul_done, div_done;
  logic [SQ_W-1:0]    sq_sum;
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic [NUM_W-1:0]   div_num_x, div_num_y;
  logic [DEN_W-1:0]   div_den;
  logic [QUO_W-1:0]   quo_x, quo_y;

  logic signed [SUM_W-1:0] term_x, term_y, vsum_x, vsum_y;
  logic signed [ACC_W-1:0] vx_sat, vy_sat;

  logic [ACC_W-1:0] vmag_x, vmag_y;
  logic             dead_clr;

  logic signed [POS_W-1:0]       psum_x, psum_y;
  logic signed [COORD_WIDTH-1:0] nx, ny;

  // self - node; its magnitude never exceeds 2^W - 1
  assign dsub_x = {self_x_r[COORD_WIDTH-1], self_x_r} - {px_r[COORD_WIDTH-1], px_r};
  assign dsub_y = {self_y_r[COORD_WIDTH-1], self_y_r} - {py_r[COORD_WIDTH-1], py_r};
  assign mag_x  = dsub_x[DIFF_W-1] ? MAG_W'(-dsub_x) : MAG_W'(dsub_x);
  assign mag_y  = dsub_y[DIFF_W-1] ? MAG_W'(-dsub_y) : MAG_W'(dsub_y);

  assign rep_skip = ((mag_x == '0) && (mag_y == '0))
                 || (|(mag_x >> BIG_BIT)) || (|(mag_y >> BIG_BIT));
  assign att_skip = (adiv_r == '0);

  // attraction divisor (edges + 1) * weight, weight 0 taken as 1
  assign edge_cl  = (32'(edge_r) > 32'(MAX_EDGES)) ? EDGE_W'(MAX_EDGES) : edge_r;
  assign edge_p1  = {1'b0, edge_cl} + (EDGE_W+1)'(1);
  assign w_eff    = (weight_r == '0) ? CFG_W'(1) : weight_r;
  assign adiv_new = ADIV_W'(edge_p1) * ADIV_W'(w_eff);

  flns_mul #(
    .MAG_W (MAG_W)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (mul_go),
    .mag_x  (mag_x),
    .mag_y  (mag_y),
    .gain   (gain_r),
    .done   (mul_done),
    .sq_sum (sq_sum),
    .prod_x (prod_x),
    .prod_y (prod_y)
  );

  // repel: |d| * g * 2^15 / (dx^2 + dy^2); attract: |d| * 2^7 / divisor
  assign div_num_x = use_mul ? NUM_W'({prod_x, {REPEL_SHIFT{1'b0}}})
                             : NUM_W'({mag_x, {ATTR_SHIFT{1'b0}}});
  assign div_num_y = use_mul ? NUM_W'({prod_y, {REPEL_SHIFT{1'b0}}})
                             : NUM_W'({mag_y, {ATTR_SHIFT{1'b0}}});
  assign div_den   = use_mul ? DEN_W'(sq_sum) : DEN_W'(adiv_r);

  flns_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num_x (div_num_x),
    .num_y (div_num_y),
    .den   (div_den),
    .done  (div_done),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  // saturating velocity accumulation
  assign term_x = sx_r ? -(SUM_W'(quo_x)) : SUM_W'(quo_x);
  assign term_y = sy_r ? -(SUM_W'(quo_y)) : SUM_W'(quo_y);
  assign vsum_x = {{(SUM_W-ACC_W){vel_x_r[ACC_W-1]}}, vel_x_r} + term_x;
  assign vsum_y = {{(SUM_W-ACC_W){vel_y_r[ACC_W-1]}}, vel_y_r} + term_y;

  assign vx_sat = ((vsum_x[SUM_W-1:ACC_W-1] == '0) || (vsum_x[SUM_W-1:ACC_W-1] == '1))
                ? vsum_x[ACC_W-1:0]
                : {vsum_x[SUM_W-1], {(ACC_W-1){~vsum_x[SUM_W-1]}}};
  assign vy_sat = ((vsum_y[SUM_W-1:ACC_W-1] == '0) || (vsum_y[SUM_W-1:ACC_W-1] == '1))
                ? vsum_y[ACC_W-1:0]
                : {vsum_y[SUM_W-1], {(ACC_W-1){~vsum_y[SUM_W-1]}}};

  // dead zone
  assign vmag_x   = vel_x_r[ACC_W-1] ? ACC_W'(-vel_x_r) : ACC_W'(vel_x_r);
  assign vmag_y   = vel_y_r[ACC_W-1] ? ACC_W'(-vel_y_r) : ACC_W'(vel_y_r);
  assign dead_clr = !held_r && (vmag_x < ACC_W'(dz_r)) && (vmag_y < ACC_W'(dz_r));

  // new position, saturated to the coordinate range
  assign psum_x = {{(POS_W-COORD_WIDTH){self_x_r[COORD_WIDTH-1]}}, self_x_r}
                + {{(POS_W-ACC_W){vel_x_r[ACC_W-1]}}, vel_x_r};
  assign psum_y = {{(POS_W-COORD_WIDTH){self_y_r[COORD_WIDTH-1]}}, self_y_r}
                + {{(POS_W-ACC_W){vel_y_r[ACC_W-1]}}, vel_y_r};

  always_comb begin
    if (held_r) begin
      nx = self_x_r;
      ny = self_y_r;
    end else begin
      nx = ((psum_x[POS_W-1:COORD_WIDTH-1] == '0) || (psum_x[POS_W-1:COORD_WIDTH-1] == '1))
         ? psum_x[COORD_WIDTH-1:0]
         : {psum_x[POS_W-1], {(COORD_WIDTH-1){~psum_x[POS_W-1]}}};
      ny = ((psum_y[POS_W-1:COORD_WIDTH-1] == '0) || (psum_y[POS_W-1:COORD_WIDTH-1] == '1))
         ? psum_y[COORD_WIDTH-1:0]
         : {psum_y[POS_W-1], {(COORD_WIDTH-1){~psum_y[POS_W-1]}}};
    end
  end

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_PREP;
      end
      S_PREP: begin
        priority if (req_r == REQ_REPEL && !rep_skip) begin
          state_nxt = S_MUL;
        end else if (req_r == REQ_ATTRACT && !att_skip) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = last_r ? S_DEAD : S_IDLE;
        end
      end
      S_MUL: begin
        if (mul_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = last_r ? S_DEAD : S_IDLE;
      end
      S_DEAD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = (state_r != S_IDLE);
    ld_item  = (state_r == S_IDLE) && start;
    prep_en  = (state_r == S_PREP);
    ld_start = prep_en && (req_r == REQ_START);
    mul_go   = prep_en && (req_r == REQ_REPEL) && !rep_skip;
    use_mul  = (state_r == S_MUL);
    div_go   = (prep_en && (req_r == REQ_ATTRACT) && !att_skip) || (use_mul && mul_done);
    acc_en   = (state_r == S_ACC);
    dead_en  = (state_r == S_DEAD);
    out_en   = (state_r == S_OUT);
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    weight_nxt = weight_r;
    gain_nxt   = gain_r;
    dz_nxt     = dz_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WEIGHT: weight_nxt = cfg_wdata;
        REG_GAIN:   gain_nxt   = cfg_wdata;
        REG_DEAD:   dz_nxt     = cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    self_x_nxt = self_x_r;
    self_y_nxt = self_y_r;
    held_nxt   = held_r;
    vel_x_nxt  = vel_x_r;
    vel_y_nxt  = vel_y_r;
    adiv_nxt   = adiv_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    if (ld_start) begin
      self_x_nxt = px_r;
      self_y_nxt = py_r;
      held_nxt   = held_in_r;
      vel_x_nxt  = '0;
      vel_y_nxt  = '0;
      adiv_nxt   = adiv_new;
    end
    if (prep_en) begin
      // repel pushes along self - node, attract pulls along node - self
      sx_nxt = (req_r == REQ_REPEL) ? dsub_x[DIFF_W-1] : ~dsub_x[DIFF_W-1];
      sy_nxt = (req_r == REQ_REPEL) ? dsub_y[DIFF_W-1] : ~dsub_y[DIFF_W-1];
    end
    if (acc_en) begin
      vel_x_nxt = vx_sat;
      vel_y_nxt = vy_sat;
    end
    if (dead_en && dead_clr) begin
      vel_x_nxt = '0;
      vel_y_nxt = '0;
    end
    if (out_en) begin
      self_x_nxt = nx;
      self_y_nxt = ny;
    end
  end

  always_comb begin
    out_valid_nxt = out_en;
    new_x_nxt     = new_x_r;
    new_y_nxt     = new_y_r;
    moved_nxt     = moved_r;
    if (out_en) begin
      new_x_nxt = nx;
      new_y_nxt = ny;
      moved_nxt = (nx != self_x_r) || (ny != self_y_r);
    end
  end

  // ---------------------------------------------------------------- flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      weight_r    <= WEIGHT_RST;
      gain_r      <= GAIN_RST;
      dz_r        <= DEAD_RST;
      self_x_r    <= '0;
      self_y_r    <= '0;
      held_r      <= 1'b0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      adiv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      weight_r    <= weight_nxt;
      gain_r      <= gain_nxt;
      dz_r        <= dz_nxt;
      self_x_r    <= self_x_nxt;
      self_y_r    <= self_y_nxt;
      held_r      <= held_nxt;
      vel_x_r     <= vel_x_nxt;
      vel_y_r     <= vel_y_nxt;
      adiv_r      <= adiv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_item) begin
      req_r     <= in_req_type;
      px_r      <= in_pos_x;
      py_r      <= in_pos_y;
      edge_r    <= in_edge_count;
      held_in_r <= in_held;
      last_r    <= in_last;
    end
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    new_x_r <= new_x_nxt;
    new_y_r <= new_y_nxt;
    moved_r <= moved_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_new_x = new_x_r;
  assign out_new_y = new_y_r;
  assign out_moved = moved_r;

endmodule

`default_nettype wire

/* rtl/core/flns_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial shift-and-add multiplier: dx^2+dy^2, dx*gain and dy*gain,
// one multiplier bit per cycle. Uses flns_pkg for the gain width.

module flns_mul #(
  parameter int MAG_W = flns_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  go,
  input  logic [MAG_W-1:0]                      mag_x,
  input  logic [MAG_W-1:0]                      mag_y,
  input  logic [flns_pkg::GAIN_W-1:0]           gain,
  output logic                                  done,
  output logic [2*MAG_W:0]                      sq_sum,
  output logic [MAG_W+flns_pkg::GAIN_W-1:0]     prod_x,
  output logic [MAG_W+flns_pkg::GAIN_W-1:0]     prod_y
);
  import flns_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [MAG_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt;
  logic [MAG_W-1:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [GAIN_W-1:0] g_r, g_nxt;
  logic [MAG_W:0]    sh_r, sh_nxt;
  logic [MAG_W-1:0]  sl_r, sl_nxt;
  logic [GAIN_W-1:0] xh_r, xh_nxt, yh_r, yh_nxt;
  logic [MAG_W-1:0]  xl_r, xl_nxt, yl_r, yl_nxt;

  logic [MAG_W+1:0]  t_sq;
  logic [GAIN_W:0]   t_x, t_y;

  // product high halves take the partial sum, low halves collect the bit shifted out
  assign t_sq = {1'b0, sh_r} + (MAG_W+2)'(bx_r[0] ? ax_r : '0)
                             + (MAG_W+2)'(by_r[0] ? ay_r : '0);
  assign t_x  = {1'b0, xh_r} + (GAIN_W+1)'(bx_r[0] ? g_r : '0);
  assign t_y  = {1'b0, yh_r} + (GAIN_W+1)'(by_r[0] ? g_r : '0);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    ax_nxt   = ax_r;
    ay_nxt   = ay_r;
    bx_nxt   = bx_r;
    by_nxt   = by_r;
    g_nxt    = g_r;
    sh_nxt   = sh_r;
    sl_nxt   = sl_r;
    xh_nxt   = xh_r;
    xl_nxt   = xl_r;
    yh_nxt   = yh_r;
    yl_nxt   = yl_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      ax_nxt  = mag_x;
      ay_nxt  = mag_y;
      bx_nxt  = mag_x;
      by_nxt  = mag_y;
      g_nxt   = gain;
      sh_nxt  = '0;
      xh_nxt  = '0;
      yh_nxt  = '0;
    end else if (run_r) begin
      bx_nxt = bx_r >> 1;
      by_nxt = by_r >> 1;
      sh_nxt = t_sq[MAG_W+1:1];
      sl_nxt = {t_sq[0], sl_r[MAG_W-1:1]};
      xh_nxt = t_x[GAIN_W:1];
      xl_nxt = {t_x[0], xl_r[MAG_W-1:1]};
      yh_nxt = t_y[GAIN_W:1];
      yl_nxt = {t_y[0], yl_r[MAG_W-1:1]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(MAG_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
    bx_r <= bx_nxt;
    by_r <= by_nxt;
    g_r  <= g_nxt;
    sh_r <= sh_nxt;
    sl_r <= sl_nxt;
    xh_r <= xh_nxt;
    xl_r <= xl_nxt;
    yh_r <= yh_nxt;
    yl_r <= yl_nxt;
  end

  assign done   = done_r;
  assign sq_sum = {sh_r, sl_r};
  assign prod_x = {xh_r, xl_r};
  assign prod_y = {yh_r, yl_r};

endmodule

`default_nettype wire

/* rtl/core/flns_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Radix-2 restoring divider, two lanes (x and y) over one shared divisor,
// one quotient bit per cycle. Standalone; widths come from the core.

module flns_div #(
  parameter int NUM_W = 63,
  parameter int DEN_W = 49,
  parameter int QUO_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num_x,
  input  logic [NUM_W-1:0] num_y,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo_x,
  output logic [QUO_W-1:0] quo_y
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [DEN_W-1:0] d_r, d_nxt;
  logic [DEN_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  // numerator low bits shift out at the top while quotient bits shift in below
  logic [QUO_W-1:0] qx_r, qx_nxt, qy_r, qy_nxt;

  logic [DEN_W:0] tx, ty, dext;
  logic           gex, gey;

  assign dext = {1'b0, d_r};
  assign tx   = {rx_r, qx_r[QUO_W-1]};
  assign ty   = {ry_r, qy_r[QUO_W-1]};
  assign gex  = tx >= dext;
  assign gey  = ty >= dext;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    qx_nxt   = qx_r;
    qy_nxt   = qy_r;
    if (go) begin
      // quotient is known to fit QUO_W bits, so the upper part is below den
      run_nxt = 1'b1;
      cnt_nxt = '0;
      d_nxt   = den;
      rx_nxt  = DEN_W'(num_x >> QUO_W);
      ry_nxt  = DEN_W'(num_y >> QUO_W);
      qx_nxt  = num_x[QUO_W-1:0];
      qy_nxt  = num_y[QUO_W-1:0];
    end else if (run_r) begin
      rx_nxt  = gex ? DEN_W'(tx - dext) : tx[DEN_W-1:0];
      ry_nxt  = gey ? DEN_W'(ty - dext) : ty[DEN_W-1:0];
      qx_nxt  = {qx_r[QUO_W-2:0], gex};
      qy_nxt  = {qy_r[QUO_W-2:0], gey};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r  <= d_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
  end

  assign done  = done_r;
  assign quo_x = qx_r;
  assign quo_y = qy_r;

endmodule

`default_nettype wire

/* bench/force_layout_node_step_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for force_layout_node_step_core: directed node sets, then
// random sets under several register settings, checked against a local predictor.
// Depends on flns_pkg and the core RTL only.

module force_layout_node_step_core_test;
  import flns_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 4000;
  localparam longint VEL_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint VEL_MIN = -VEL_MAX - 1;
  localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint BIG_DIST = 64'sd1 <<< BIG_BIT;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 moved;
  } node_pos_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [REQ_W-1:0]         in_req_type;
  logic signed [CW-1:0]     in_pos_x;
  logic signed [CW-1:0]     in_pos_y;
  logic [EDGE_W-1:0]        in_edge_count;
  logic                     in_held;
  logic                     in_last;
  logic                     out_valid;
  logic signed [CW-1:0]     out_new_x;
  logic signed [CW-1:0]     out_new_y;
  logic                     out_moved;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;

  // predictor state and register copies
  longint    self_x, self_y, vel_x, vel_y, edge_divisor;
  bit        node_held;
  longint    weight_reg, gain_reg, dead_reg;
  node_pos_t expected_positions[$];
  int        mismatch_count;
  bit        steady;

  int unsigned weight_set[6] = '{256, 1, 65535, 0, 0, 0};
  int unsigned gain_set[6]   = '{150, 65535, 0, 1000, 0, 0};
  int unsigned dead_set[6]   = '{256, 0, 65535, 16, 0, 0};

  force_layout_node_step_core #(.COORD_WIDTH(CW)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_edge_count (in_edge_count),
    .in_held       (in_held),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_new_x     (out_new_x),
    .out_new_y     (out_new_y),
    .out_moved     (out_moved),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint add_velocity(longint a, longint b);
    longint s;
    s = a + b;
    if (s > VEL_MAX) return VEL_MAX;
    if (s < VEL_MIN) return VEL_MIN;
    return s;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // trunc(sign * num / den), toward zero
  function automatic longint force_term(bit neg, longint num, longint den);
    return neg ? -(num / den) : (num / den);
  endfunction

  task automatic advance_node_state(input logic [REQ_W-1:0] kind,
                                    input logic signed [CW-1:0] px_in,
                                    input logic signed [CW-1:0] py_in,
                                    input logic [EDGE_W-1:0] edges,
                                    input logic hold, input logic fin);
    longint    px, py, dx, dy, ax, ay, den, k, e, nx, ny, vx, vy;
    node_pos_t pos;
    px = longint'(px_in);
    py = longint'(py_in);
    case (kind)
      REQ_START: begin
        e = longint'(edges);
        if (e > MAX_EDGES) e = MAX_EDGES;
        self_x = px;
        self_y = py;
        node_held = hold;
        vel_x = 0;
        vel_y = 0;
        edge_divisor = (e + 1) * ((weight_reg == 0) ? 1 : weight_reg);
      end
      REQ_REPEL: begin
        dx = self_x - px;
        dy = self_y - py;
        ax = magnitude(dx);
        ay = magnitude(dy);
        if ((dx != 0 || dy != 0) && ax < BIG_DIST && ay < BIG_DIST) begin
          den = ax * ax + ay * ay;
          k = gain_reg <<< REPEL_SHIFT;
          vel_x = add_velocity(vel_x, force_term(dx < 0, ax * k, den));
          vel_y = add_velocity(vel_y, force_term(dy < 0, ay * k, den));
        end
      end
      REQ_ATTRACT: begin
        if (edge_divisor != 0) begin
          dx = px - self_x;
          dy = py - self_y;
          vel_x = add_velocity(vel_x,
                               force_term(dx < 0, magnitude(dx) <<< ATTR_SHIFT, edge_divisor));
          vel_y = add_velocity(vel_y,
                               force_term(dy < 0, magnitude(dy) <<< ATTR_SHIFT, edge_divisor));
        end
      end
      default: ;
    endcase
    if (fin) begin
      nx = self_x;
      ny = self_y;
      if (!node_held) begin
        vx = vel_x;
        vy = vel_y;
        if (magnitude(vx) < dead_reg && magnitude(vy) < dead_reg) begin
          vx = 0;
          vy = 0;
          vel_x = 0;
          vel_y = 0;
        end
        nx = clamp_coord(self_x + vx);
        ny = clamp_coord(self_y + vy);
      end
      pos.x = nx[CW-1:0];
      pos.y = ny[CW-1:0];
      pos.moved = (nx != self_x) || (ny != self_y);
      self_x = nx;
      self_y = ny;
      expected_positions.push_back(pos);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    node_pos_t pos;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("unexpected result, new_x", longint'(out_new_x), 64'sd0);
      end else begin
        pos = expected_positions.pop_front();
        if (out_new_x !== pos.x)
          report_mismatch("new_x", longint'(out_new_x), longint'(pos.x));
        if (out_new_y !== pos.y)
          report_mismatch("new_y", longint'(out_new_y), longint'(pos.y));
        if (out_moved !== pos.moved)
          report_mismatch("moved", longint'(out_moved), longint'(pos.moved));
      end
    end
  end

  // ends the run if nothing moves for too long
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 || cfg_wr_en)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [REQ_W-1:0] kind, input logic signed [CW-1:0] px,
                           input logic signed [CW-1:0] py, input logic [EDGE_W-1:0] edges,
                           input logic hold, input logic fin);
    if (!steady && $urandom_range(99) < 24)
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 70 : 5)) @(negedge clk);
    @(negedge clk);
    in_req_type = kind;
    in_pos_x = px;
    in_pos_y = py;
    in_edge_count = edges;
    in_held = hold;
    in_last = fin;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    advance_node_state(kind, px, py, edges, hold, fin);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_WEIGHT: weight_reg = longint'(val);
      REG_GAIN:   gain_reg = longint'(val);
      REG_DEAD:   dead_reg = longint'(val);
      default: ;
    endcase
  endtask

  // all results in, and time for an item without last to finish
  task automatic wait_idle();
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] near_coord(longint c);
    longint v;
    case ($urandom_range(3))
      0: v = c + longint'($urandom_range(2048)) - 1024;
      1: v = c + longint'($urandom_range(131072)) - 65536;
      2: v = c + longint'($urandom_range(1 << 23)) - (1 << 22);
      default: v = longint'($urandom);
    endcase
    return v[CW-1:0];
  endfunction

  task automatic test_no_start_after_reset();
    send_item(REQ_ATTRACT, 24'sd1000, -24'sd1000, 8'd3, 1'b0, 1'b0);
    send_item(REQ_REPEL, 24'sd0, 24'sd0, 8'd0, 1'b0, 1'b0);   // zero distance
    send_item(REQ_UNUSED, 24'sd77, 24'sd77, 8'd255, 1'b1, 1'b1);
  endtask

  task automatic test_held_node();
    send_item(REQ_START, 24'sh7FFFFF, 24'sh800000, 8'd255, 1'b1, 1'b1);
    send_item(REQ_REPEL, 24'sd0, 24'sd0, 8'd0, 1'b0, 1'b1);
  endtask

  task automatic test_repulsion();
    send_item(REQ_START, 24'sd0, 24'sd0, 8'd0, 1'b0, 1'b0);
    send_item(REQ_REPEL, 24'sd256, 24'sd0, 8'd0, 1'b0, 1'b0);
    send_item(REQ_REPEL, 24'sd0, 24'sd0, 8'd0, 1'b0, 1'b0);
    send_item(REQ_REPEL, 24'sh800000, 24'sh7FFFFF, 8'd0, 1'b0, 1'b0);
    send_item(REQ_ATTRACT, 24'sd512, 24'sd512, 8'd0, 1'b0, 1'b1);
  endtask

  task automatic test_dead_zone();
    send_item(REQ_START, 24'sd100, 24'sd100, 8'd0, 1'b0, 1'b0);
    send_item(REQ_ATTRACT, 24'sd101, 24'sd101, 8'd0, 1'b0, 1'b0);
    send_item(REQ_ATTRACT, 24'sd400, 24'sd100, 8'd0, 1'b0, 1'b0);
    send_item(REQ_UNUSED, 24'sd0, 24'sd0, 8'd0, 1'b0, 1'b1);
  endtask

  task automatic test_saturation_and_zero_weight();
    wait_idle();
    write_register(REG_GAIN, 16'hFFFF);
    write_register(REG_WEIGHT, 16'd1);
    write_register(REG_DEAD, 16'd0);
    send_item(REQ_START, 24'sd8388600, -24'sd8388600, 8'd0, 1'b0, 1'b0);
    send_item(REQ_REPEL, 24'sd8388599, -24'sd8388599, 8'd0, 1'b0, 1'b1);
    send_item(REQ_ATTRACT, 24'sh800000, 24'sh7FFFFF, 8'd0, 1'b0, 1'b1);
    wait_idle();
    write_register(REG_WEIGHT, 16'd0);
    send_item(REQ_START, 24'sd0, 24'sd0, 8'd0, 1'b0, 1'b0);
    send_item(REQ_ATTRACT, 24'sd1048576, -24'sd1048576, 8'd0, 1'b0, 1'b1);
  endtask

  task automatic test_random_layout(input int n_items);
    int     done, len;
    longint cx, cy;
    logic [REQ_W-1:0] kind;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 85) begin
        // well-formed set: start, up to six force items, last on the final one
        if ($urandom_range(1)) begin
          cx = longint'($urandom_range(131072)) - 65536;
          cy = longint'($urandom_range(131072)) - 65536;
        end else begin
          cx = longint'(near_coord(64'sd0));
          cy = longint'(near_coord(64'sd0));
        end
        len = $urandom_range(0, 6);
        send_item(REQ_START, cx[CW-1:0], cy[CW-1:0],
                  EDGE_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(8)),
                  $urandom_range(7) == 0, len == 0);
        for (int i = 1; i <= len; i++) begin
          kind = $urandom_range(1) ? REQ_REPEL : REQ_ATTRACT;
          send_item(kind, near_coord(cx), near_coord(cy), EDGE_W'($urandom),
                    1'($urandom), i == len);
        end
        done += len + 1;
      end else begin
        send_item(REQ_W'($urandom), CW'($urandom), CW'($urandom), EDGE_W'($urandom),
                  1'($urandom), 1'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_START;
    in_pos_x = '0;
    in_pos_y = '0;
    in_edge_count = '0;
    in_held = 1'b0;
    in_last = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_WEIGHT;
    cfg_wdata = '0;
    self_x = 0;
    self_y = 0;
    vel_x = 0;
    vel_y = 0;
    edge_divisor = 0;
    node_held = 1'b0;
    weight_reg = longint'(WEIGHT_RST);
    gain_reg = longint'(GAIN_RST);
    dead_reg = longint'(DEAD_RST);
    mismatch_count = 0;
    steady = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_no_start_after_reset();
    test_held_node();
    test_repulsion();
    test_dead_zone();
    test_saturation_and_zero_weight();

    for (int p = 0; p < 6; p++) begin
      if (p >= 4) begin
        weight_set[p] = $urandom_range(65535);
        gain_set[p] = $urandom_range(65535);
        dead_set[p] = $urandom_range(4096);
      end
      wait_idle();
      write_register(REG_WEIGHT, CFG_W'(weight_set[p]));
      write_register(REG_GAIN, CFG_W'(gain_set[p]));
      write_register(REG_DEAD, CFG_W'(dead_set[p]));
      steady = (p == 2);
      test_random_layout(65);
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/flns_pkg.sv
rtl/core/flns_mul.sv
rtl/core/flns_div.sv
rtl/core/force_layout_node_step_core.sv
bench/force_layout_node_step_core_test.sv
